[hdl/mrr_pkg.sv]
// Shared constants and types of the XY mesh router.
// No dependencies; the controller, datapath and top level use it.
package mrr_pkg;
   localparam int NPORTS    = 5;
   localparam int MAX_QUEUE = 16;
   localparam int IN_CAP    = MAX_QUEUE + 1;

   localparam logic [1:0] CMD_ARRIVE  = 2'd0;
   localparam logic [1:0] CMD_STALL   = 2'd1;
   localparam logic [1:0] CMD_UNSTALL = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   localparam logic [1:0] KIND_ANSWER  = 2'd0;
   localparam logic [1:0] KIND_FORWARD = 2'd1;
   localparam logic [1:0] KIND_UNSTALL = 2'd2;

   localparam logic [2:0] PORT_RIGHT = 3'd0;
   localparam logic [2:0] PORT_LEFT  = 3'd1;
   localparam logic [2:0] PORT_UP    = 3'd2;
   localparam logic [2:0] PORT_DOWN  = 3'd3;
   localparam logic [2:0] PORT_LOCAL = 3'd4;

   localparam logic [1:0] CSR_OWN_X = 2'd0;
   localparam logic [1:0] CSR_OWN_Y = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   typedef struct packed {
      logic latch;
      logic arrive;
      logic ctl;
      logic tick_init;
      logic gread;
      logic gdo;
      logic sread;
      logic sdo;
      logic adv;
      logic flush;
   } mrr_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       head_ne;
      logic       send_ok;
      logic       scan_end;
   } mrr_status_type;
endpackage

[hdl/mesh_router_xy_round_robin.sv]
// Top level of the five-port XY mesh router with round-robin arbitration.
// Depends on mrr_pkg, mrr_ctrl and mrr_dp.
//
// A request is taken on a rising edge with start high and busy low. Its
// command is arrive, stall output, unstall output or tick. Results leave on
// the rsp_ ports, each marked by rsp_valid for a single cycle;
// rsp_last flags the final result of a request. The receiver cannot stall,
// so results are never held back.
// An arrive, stall or unstall request passes through a decode and a flush
// state. A tick walks the five inputs in round-robin order and then the five
// outputs in port order, one port at a time, with a queue memory read for
// each port that has an entry to move or send. The last result is on the
// ports in the first cycle in which busy is low again.
// Configuration writes through csr_we, csr_index and csr_wdata are taken on
// any edge outside reset; they should only be issued while the block is idle.
// Reset (synchronous, active high) empties every queue, clears the stall
// marks and the round-robin pointer, and restores the queue limit to four.
// Queue contents are not cleared; only written entries are ever read.
module mesh_router_xy_round_robin (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_port,
   input  logic [3:0]  req_dst_x,
   input  logic [3:0]  req_dst_y,
   input  logic [15:0] req_tag,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_out_port,
   output logic [15:0] rsp_out_tag,
   output logic [3:0]  rsp_out_dest_x,
   output logic [3:0]  rsp_out_dest_y,
   output logic        rsp_stall_upstream,
   output logic        rsp_last
);
   mrr_pkg::mrr_cmd_type    cmd;
   mrr_pkg::mrr_status_type status;
   logic                    accept;

   // A request is taken only while the sequencer is idle.
   assign accept = start && !busy;

   mrr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   mrr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .in_cmd             (req_cmd),
      .in_port            (req_port),
      .in_dest_x          (req_dst_x),
      .in_dest_y          (req_dst_y),
      .in_tag             (req_tag),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_out_port       (rsp_out_port),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_out_dest_x     (rsp_out_dest_x),
      .rsp_out_dest_y     (rsp_out_dest_y),
      .rsp_stall_upstream (rsp_stall_upstream),
      .rsp_last           (rsp_last)
   );
endmodule

[hdl/mrr_ctrl.sv]
// Sequencing state machine of the XY mesh router.
// Depends on mrr_pkg; drives the datapath through command and status structs.
module mrr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  mrr_pkg::mrr_status_type status,
   output mrr_pkg::mrr_cmd_type    cmd,
   output logic                    busy
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_GREAD  = 3'd2;
   localparam logic [2:0] S_GDO    = 3'd3;
   localparam logic [2:0] S_SREAD  = 3'd4;
   localparam logic [2:0] S_SDO    = 3'd5;
   localparam logic [2:0] S_FLUSH  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.latch = accept;
            if (accept) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (status.cmd == mrr_pkg::CMD_TICK) begin
               cmd.tick_init = 1'b1;
               state_in = S_GREAD;
            end else begin
               if (status.cmd == mrr_pkg::CMD_ARRIVE) cmd.arrive = 1'b1;
               else cmd.ctl = 1'b1;
               state_in = S_FLUSH;
            end
         end
         S_GREAD: begin
            if (status.head_ne) begin
               cmd.gread = 1'b1;
               state_in = S_GDO;
            end else begin
               cmd.adv = 1'b1;
               if (status.scan_end) state_in = S_SREAD;
            end
         end
         S_GDO: begin
            cmd.gdo = 1'b1;
            cmd.adv = 1'b1;
            state_in = status.scan_end ? S_SREAD : S_GREAD;
         end
         S_SREAD: begin
            if (status.send_ok) begin
               cmd.sread = 1'b1;
               state_in = S_SDO;
            end else begin
               cmd.adv = 1'b1;
               if (status.scan_end) state_in = S_FLUSH;
            end
         end
         S_SDO: begin
            cmd.sdo = 1'b1;
            cmd.adv = 1'b1;
            state_in = status.scan_end ? S_FLUSH : S_SREAD;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule

[hdl/mrr_dp.sv]
// Datapath of the XY mesh router: queues, counts, arbitration and result stage.
// Depends on mrr_pkg; steered by mrr_ctrl.
module mrr_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  mrr_pkg::mrr_cmd_type    cmd,
   output mrr_pkg::mrr_status_type status,
   input  logic [1:0]              in_cmd,
   input  logic [2:0]              in_port,
   input  logic [3:0]              in_dest_x,
   input  logic [3:0]              in_dest_y,
   input  logic [15:0]             in_tag,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [4:0]              csr_wdata,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [2:0]              rsp_out_port,
   output logic [15:0]             rsp_out_tag,
   output logic [3:0]              rsp_out_dest_x,
   output logic [3:0]              rsp_out_dest_y,
   output logic                    rsp_stall_upstream,
   output logic                    rsp_last
);
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  port;
      logic [15:0] tag;
      logic [3:0]  dx;
      logic [3:0]  dy;
      logic        stall;
   } res_type;

   logic [3:0] own_x_ff, own_y_ff;
   logic [4:0] limit_ff;
   logic [1:0] cmd_ff;
   logic [2:0] port_ff;
   logic [3:0] dx_ff, dy_ff;
   logic [15:0] tag_ff;

   logic [4:0] icnt_ff [mrr_pkg::NPORTS];
   logic [4:0] ihead_ff [mrr_pkg::NPORTS];
   logic [4:0] ocnt_ff [mrr_pkg::NPORTS];
   logic [3:0] ohead_ff [mrr_pkg::NPORTS];
   logic [mrr_pkg::NPORTS-1:0] stalled_ff, taken_ff, before_ff;
   logic [2:0] rr_ff, idx_ff, step_ff;

   logic [23:0] imem [mrr_pkg::NPORTS * mrr_pkg::IN_CAP];
   logic [23:0] omem [mrr_pkg::NPORTS * mrr_pkg::MAX_QUEUE];
   logic [23:0] ird_ff, ord_ff;

   res_type pend_ff, rsp_ff;
   logic pend_v_ff, rsp_v_ff, rsp_last_ff;

   // Effective limit, clamped to 1..MAX_QUEUE.
   logic [4:0] limit;
   always_comb begin
      if (limit_ff == 5'd0) limit = 5'd1;
      else if (limit_ff > 5'(mrr_pkg::MAX_QUEUE)) limit = 5'(mrr_pkg::MAX_QUEUE);
      else limit = limit_ff;
   end

   logic       port_ok;
   logic [4:0] acnt, aslot;
   logic [5:0] aslot_sum;
   logic [6:0] iwaddr, iraddr;
   assign port_ok = (port_ff < 3'(mrr_pkg::NPORTS));
   assign acnt = port_ok ? icnt_ff[port_ff] : 5'd0;
   assign aslot_sum = port_ok ? (6'(ihead_ff[port_ff]) + 6'(acnt)) : 6'd0;
   assign aslot = (aslot_sum >= 6'(mrr_pkg::IN_CAP)) ?
                  5'(aslot_sum - 6'(mrr_pkg::IN_CAP)) : aslot_sum[4:0];
   assign iwaddr = 7'(port_ff) * 7'(mrr_pkg::IN_CAP) + 7'(aslot);
   assign iraddr = 7'(idx_ff) * 7'(mrr_pkg::IN_CAP) + 7'(ihead_ff[idx_ff]);

   logic [3:0] hx, hy;
   logic [2:0] route;
   assign hx = ird_ff[7:4];
   assign hy = ird_ff[3:0];
   always_comb begin
      if (hx == own_x_ff && hy == own_y_ff) route = mrr_pkg::PORT_LOCAL;
      else if (hx == own_x_ff) route = (hy < own_y_ff) ? mrr_pkg::PORT_DOWN : mrr_pkg::PORT_UP;
      else route = (hx < own_x_ff) ? mrr_pkg::PORT_LEFT : mrr_pkg::PORT_RIGHT;
   end

   logic grant;
   logic [3:0] oslot;
   logic [2:0] idx_next;
   assign grant = cmd.gdo && !taken_ff[route] && (ocnt_ff[route] < limit);
   assign oslot = ohead_ff[route] + ocnt_ff[route][3:0];
   assign idx_next = (idx_ff == 3'(mrr_pkg::NPORTS - 1)) ? 3'd0 : idx_ff + 3'd1;

   // Result produced this cycle, if any.
   logic res_v;
   res_type res;
   always_comb begin
      res_v = 1'b0;
      res = '0;
      if (cmd.arrive) begin
         res_v = 1'b1;
         res.kind = mrr_pkg::KIND_ANSWER;
         res.port = port_ff;
         if (port_ok) res.stall = (acnt < 5'(mrr_pkg::IN_CAP)) ? (acnt + 5'd1 > limit) : 1'b1;
      end else if (grant && (icnt_ff[idx_ff] - 5'd1 == limit)) begin
         res_v = 1'b1;
         res.kind = mrr_pkg::KIND_UNSTALL;
         res.port = idx_ff;
      end else if (cmd.sdo) begin
         res_v = 1'b1;
         res.kind = mrr_pkg::KIND_FORWARD;
         res.port = idx_ff;
         res.tag = ord_ff[23:8];
         res.dx = ord_ff[7:4];
         res.dy = ord_ff[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arrive && port_ok && acnt < 5'(mrr_pkg::IN_CAP))
         imem[iwaddr] <= {tag_ff, dx_ff, dy_ff};
      if (cmd.gread) ird_ff <= imem[iraddr];
   end

   always_ff @(posedge clock) begin
      if (grant) omem[{route, oslot}] <= ird_ff;
      if (cmd.sread) ord_ff <= omem[{idx_ff, ohead_ff[idx_ff]}];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff <= in_cmd;
         port_ff <= in_port;
         dx_ff <= in_dest_x;
         dy_ff <= in_dest_y;
         tag_ff <= in_tag;
      end
      rsp_ff <= pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff <= '0;
         own_y_ff <= '0;
         limit_ff <= 5'd4;
         stalled_ff <= '0;
         taken_ff <= '0;
         before_ff <= '0;
         rr_ff <= '0;
         idx_ff <= '0;
         step_ff <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
         for (int p = 0; p < mrr_pkg::NPORTS; p++) begin
            icnt_ff[p] <= '0;
            ihead_ff[p] <= '0;
            ocnt_ff[p] <= '0;
            ohead_ff[p] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               mrr_pkg::CSR_OWN_X: own_x_ff <= csr_wdata[3:0];
               mrr_pkg::CSR_OWN_Y: own_y_ff <= csr_wdata[3:0];
               mrr_pkg::CSR_LIMIT: limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.arrive && port_ok && acnt < 5'(mrr_pkg::IN_CAP))
            icnt_ff[port_ff] <= acnt + 5'd1;
         if (cmd.ctl && port_ok)
            stalled_ff[port_ff] <= (cmd_ff == mrr_pkg::CMD_STALL);
         if (cmd.tick_init) begin
            idx_ff <= (rr_ff >= 3'(mrr_pkg::NPORTS)) ? 3'd0 : rr_ff;
            step_ff <= '0;
            taken_ff <= '0;
            for (int p = 0; p < mrr_pkg::NPORTS; p++) before_ff[p] <= (ocnt_ff[p] != 5'd0);
         end
         if (cmd.adv) begin
            if (step_ff == 3'(mrr_pkg::NPORTS - 1)) begin
               step_ff <= '0;
               idx_ff <= '0;
            end else begin
               step_ff <= step_ff + 3'd1;
               idx_ff <= idx_next;
            end
         end
         if (cmd.gdo) taken_ff[route] <= 1'b1;
         if (grant) begin
            ocnt_ff[route] <= ocnt_ff[route] + 5'd1;
            icnt_ff[idx_ff] <= icnt_ff[idx_ff] - 5'd1;
            ihead_ff[idx_ff] <= (ihead_ff[idx_ff] == 5'(mrr_pkg::IN_CAP - 1)) ?
                                5'd0 : ihead_ff[idx_ff] + 5'd1;
            rr_ff <= idx_next;
         end
         if (cmd.sdo) begin
            ocnt_ff[idx_ff] <= ocnt_ff[idx_ff] - 5'd1;
            ohead_ff[idx_ff] <= ohead_ff[idx_ff] + 4'd1;
         end
         // One-deep holding stage: a result leaves once its successor is known.
         rsp_v_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
         if (res_v) begin
            rsp_v_ff <= pend_v_ff;
            pend_v_ff <= 1'b1;
         end else if (cmd.flush) begin
            rsp_v_ff <= pend_v_ff;
            rsp_last_ff <= 1'b1;
            pend_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_v) pend_ff <= res;
   end

   assign status.cmd = cmd_ff;
   assign status.head_ne = (icnt_ff[idx_ff] != 5'd0);
   assign status.send_ok = before_ff[idx_ff] && !stalled_ff[idx_ff];
   assign status.scan_end = (step_ff == 3'(mrr_pkg::NPORTS - 1));

   assign rsp_valid = rsp_v_ff;
   assign rsp_kind = rsp_ff.kind;
   assign rsp_out_port = rsp_ff.port;
   assign rsp_out_tag = rsp_ff.tag;
   assign rsp_out_dest_x = rsp_ff.dx;
   assign rsp_out_dest_y = rsp_ff.dy;
   assign rsp_stall_upstream = rsp_ff.stall;
   assign rsp_last = rsp_last_ff;
endmodule
